>>> design/bmpdisp_pkg.sv
// Shared types, codes and helpers for the BMP to RGB565 display stream.
// No dependencies; imported by the top level and the parse and emit modules.
package bmpdisp_pkg;

    localparam int unsigned MAX_IMAGE_WIDTH = 1280;
    localparam int unsigned HDR_LAST_POS    = 33;
    localparam int unsigned MIN_DATA_POS    = 34;

    localparam logic [7:0] CMD_COL_ADDR = 8'h2A;
    localparam logic [7:0] CMD_ROW_ADDR = 8'h2B;
    localparam logic [7:0] CMD_MEM_WR   = 8'h2C;

    // emit sequence positions: 0..10 window burst, then pixel, finish, single
    localparam logic [3:0] SEQ_BURST_END = 4'd10;
    localparam logic [3:0] SEQ_PIXEL     = 4'd11;
    localparam logic [3:0] SEQ_FINISH    = 4'd12;
    localparam logic [3:0] SEQ_SINGLE    = 4'd13;

    typedef enum logic [2:0] {
        K_CLEAR  = 3'd0,
        K_CMD    = 3'd1,
        K_PARAM  = 3'd2,
        K_PIXEL  = 3'd3,
        K_REJECT = 3'd4,
        K_FINISH = 3'd5
    } t_kind;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_WAIT   = 2'd1,
        PH_ROWS   = 2'd2,
        PH_DONE   = 2'd3
    } t_phase;

    typedef struct packed {
        logic        any;
        logic        single;
        t_kind       single_kind;
        logic        burst;
        logic        pixel;
        logic        finish;
        logic [10:0] c0;
        logic [10:0] c1;
        logic [10:0] row;
        logic [15:0] pix;
    } t_bundle;

    typedef struct packed {
        t_kind       kind;
        logic [15:0] value;
    } t_item;

    function automatic t_item burst_item(input logic [3:0] idx, input logic [10:0] c0,
                                         input logic [10:0] c1, input logic [10:0] row);
        t_item it;
        it.kind  = K_PARAM;
        it.value = '0;
        case (idx)
            4'd0: begin
                it.kind  = K_CMD;
                it.value = {8'h00, CMD_COL_ADDR};
            end
            4'd1: it.value = {13'h0000, c0[10:8]};
            4'd2: it.value = {8'h00, c0[7:0]};
            4'd3: it.value = {13'h0000, c1[10:8]};
            4'd4: it.value = {8'h00, c1[7:0]};
            4'd5: begin
                it.kind  = K_CMD;
                it.value = {8'h00, CMD_ROW_ADDR};
            end
            4'd6: it.value = {13'h0000, row[10:8]};
            4'd7: it.value = {8'h00, row[7:0]};
            4'd8: it.value = {13'h0000, row[10:8]};
            4'd9: it.value = {8'h00, row[7:0]};
            4'd10: begin
                it.kind  = K_CMD;
                it.value = {8'h00, CMD_MEM_WR};
            end
            default: it.value = '0;
        endcase
        return it;
    endfunction

endpackage

>>> design/bmpdisp_byte_if.sv
// Input channel carrying one BMP file byte per transfer.
// Depends on nothing.
interface bmpdisp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] file_byte;
    logic       start_of_file;

    modport source (output valid, output file_byte, output start_of_file, input ready);
    modport sink (input valid, input file_byte, input start_of_file, output ready);
endinterface

>>> design/bmpdisp_res_if.sv
// Output channel carrying one display result per transfer.
// Depends on nothing.
interface bmpdisp_res_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [15:0] value;
    logic        last;

    modport source (output valid, output kind, output value, output last, input ready);
    modport sink (input valid, input kind, input value, input last, output ready);
endinterface

>>> design/bmp24_to_rgb565_display_stream.sv
// Top level of the 24-bit BMP to RGB565 display stream.
// Depends on bmpdisp_pkg, bmpdisp_byte_if, bmpdisp_res_if, bmpdisp_parse, bmpdisp_emit.
//
//   channel   dir  payload                        per transfer
//   s_in      in   file_byte, start_of_file       one file byte
//   m_out     out  kind, value, last              one result
//   i_cfg_*   in   i_cfg_idx, i_cfg_data          one register write
//
// A byte is taken on a transfer; its results go out one per cycle after it while m_out
// is ready. The first byte of a drawn row carries an 11-result window burst; it and a
// final pixel with finish block input until their last result is taken. Other bytes
// stream at one per cycle unless m_out stalls. Synchronous active-low reset restores
// all state but the held result bundle; input stalls while the sequencer holds results.
module bmp24_to_rgb565_display_stream (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [1:0]    i_cfg_idx,
    input  logic [9:0]    i_cfg_data,
    bmpdisp_byte_if.sink  s_in,
    bmpdisp_res_if.source m_out
);
    import bmpdisp_pkg::*;

    logic    fire, in_ready;
    t_bundle bundle;

    assign s_in.ready = in_ready;
    assign fire       = s_in.valid && in_ready;

    bmpdisp_parse u_parse (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (fire),
        .i_byte     (s_in.file_byte),
        .i_sof      (s_in.start_of_file),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_bundle   (bundle)
    );

    bmpdisp_emit u_emit (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (fire),
        .i_bundle   (bundle),
        .o_in_ready (in_ready),
        .m_out      (m_out)
    );

endmodule

>>> design/bmpdisp_parse.sv
// Header parser, geometry, row walker and pixel packer; one byte per cycle while input is accepted.
// Depends on bmpdisp_pkg.
module bmpdisp_parse (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_fire,
    input  logic [7:0]           i_byte,
    input  logic                 i_sof,
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_idx,
    input  logic [9:0]           i_cfg_data,
    output bmpdisp_pkg::t_bundle o_bundle
);
    import bmpdisp_pkg::*;

    logic [9:0]  r_dw, r_dh;
    logic [7:0]  r_coff, r_roff;
    logic [31:0] r_pos, r_pdo, r_ih, r_hs, r_fro;
    logic [10:0] r_iw, r_pix;
    logic [11:0] r_stride, r_bir;
    logic [9:0]  r_xs, r_xe, r_ys, r_row;
    logic [1:0]  r_cph;
    logic [15:0] r_chold;
    t_phase      r_phase;

    logic [31:0] n_pos, n_pdo, n_ih, n_hs, n_fro;
    logic [10:0] n_iw, n_pix;
    logic [11:0] n_stride, n_bir;
    logic [9:0]  n_xs, n_xe, n_ys, n_row;
    logic [1:0]  n_cph;
    logic [15:0] n_chold;
    t_phase      n_phase;

    logic [31:0] pos, hs, ih, pdo, fro, prod, hdiff;
    logic [10:0] iw, dw, dh, win_w, xs11, ys11;
    logic [12:0] stride13;
    logic        fld_on, taller, do_row;
    logic [1:0]  fld_idx;
    t_bundle     bnd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dw   <= 10'd176;
            r_dh   <= 10'd220;
            r_coff <= '0;
            r_roff <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                2'd0:    r_dw   <= i_cfg_data;
                2'd1:    r_dh   <= i_cfg_data;
                2'd2:    r_coff <= i_cfg_data[7:0];
                2'd3:    r_roff <= i_cfg_data[7:0];
                default: r_dw   <= r_dw;
            endcase
        end
    end

    always_comb begin
        fld_on  = 1'b1;
        fld_idx = 2'd0;
        case (pos[5:0])
            6'd10, 6'd18, 6'd22, 6'd26, 6'd28, 6'd30: fld_idx = 2'd0;
            6'd11, 6'd19, 6'd23, 6'd27, 6'd29, 6'd31: fld_idx = 2'd1;
            6'd12, 6'd20, 6'd24, 6'd32:               fld_idx = 2'd2;
            6'd13, 6'd21, 6'd25, 6'd33:               fld_idx = 2'd3;
            default:                                  fld_on  = 1'b0;
        endcase
        if (pos[31:6] != '0) begin
            fld_on = 1'b0;
        end
    end

    assign dw       = (r_dw == '0) ? 11'd1 : {1'b0, r_dw};
    assign dh       = (r_dh == '0) ? 11'd1 : {1'b0, r_dh};
    assign taller   = ih > {21'd0, dh};
    assign hdiff    = ih - {21'd0, dh};
    assign stride13 = ({2'b00, iw} * 13'd3 + 13'd3) & ~13'd3;
    assign prod     = hdiff * {20'd0, stride13[11:0]};
    assign win_w    = {1'b0, r_xe} - {1'b0, r_xs} + 11'd1;
    assign xs11     = ({1'b0, r_dw == '0 ? 10'd1 : r_dw} - iw) >> 1;
    assign ys11     = (dh - ih[10:0]) >> 1;

    always_comb begin
        pos = i_sof ? '0 : r_pos;
        hs  = i_sof ? '0 : r_hs;
        ih  = i_sof ? '0 : r_ih;
        iw  = i_sof ? '0 : r_iw;
        pdo = i_sof ? '0 : r_pdo;
        fro = pdo + (taller ? prod : 32'd0);

        n_phase  = i_sof ? PH_HEADER : r_phase;
        n_pos    = (pos == '1) ? pos : pos + 32'd1;
        n_hs     = hs;
        n_ih     = ih;
        n_iw     = iw;
        n_pdo    = pdo;
        n_fro    = r_fro;
        n_stride = r_stride;
        n_xs     = r_xs;
        n_xe     = r_xe;
        n_ys     = r_ys;
        n_row    = r_row;
        n_pix    = r_pix;
        n_bir    = r_bir;
        n_cph    = r_cph;
        n_chold  = r_chold;
        do_row   = 1'b0;

        bnd             = '0;
        bnd.single_kind = K_CLEAR;
        bnd.c0          = {3'd0, r_coff} + {1'b0, r_xs};
        bnd.c1          = {3'd0, r_coff} + {1'b0, r_xe};
        bnd.row         = {3'd0, r_roff} + {1'b0, r_row};

        case (n_phase)
            PH_HEADER: begin
                if (fld_on) begin
                    n_hs = ((fld_idx == 2'd0) ? 32'd0 : hs)
                         | ({24'd0, i_byte} << {fld_idx, 3'b000});
                end
                if (pos[31:6] == '0) begin
                    case (pos[5:0])
                        6'd13: n_pdo = n_hs;
                        6'd21: n_iw = (n_hs >= 32'd1 && n_hs <= MAX_IMAGE_WIDTH) ?
                                      n_hs[10:0] : 11'd0;
                        6'd25: n_ih = n_hs;
                        6'd27: if (n_hs != 32'd1) n_ih = '0;
                        6'd29: if (n_hs != 32'd24) n_ih = '0;
                        6'd33: begin
                            bnd.any    = 1'b1;
                            bnd.single = 1'b1;
                            if (n_hs != '0 || iw == '0 || ih == '0) begin
                                n_phase         = PH_DONE;
                                bnd.single_kind = K_REJECT;
                            end else begin
                                if (iw > dw) begin
                                    n_xs = '0;
                                    n_xe = dw[9:0] - 10'd1;
                                end else begin
                                    n_xs = xs11[9:0];
                                    n_xe = xs11[9:0] + iw[9:0] - 10'd1;
                                end
                                n_stride = stride13[11:0];
                                n_fro    = fro;
                                if (fro < MIN_DATA_POS) begin
                                    n_phase         = PH_DONE;
                                    bnd.single_kind = K_REJECT;
                                end else begin
                                    n_ys    = taller ? 10'd0 : ys11[9:0];
                                    n_row   = taller ? dh[9:0] - 10'd1 :
                                              ys11[9:0] + ih[9:0] - 10'd1;
                                    n_pix   = '0;
                                    n_bir   = '0;
                                    n_cph   = '0;
                                    n_chold = '0;
                                    n_phase = PH_WAIT;
                                end
                            end
                        end
                        default: n_hs = n_hs;
                    endcase
                end
            end
            PH_WAIT: begin
                if (pos == r_fro) begin
                    n_phase = PH_ROWS;
                    do_row  = 1'b1;
                end
            end
            PH_ROWS: do_row = 1'b1;
            default: do_row = 1'b0;
        endcase

        if (do_row) begin
            if (r_bir == '0) begin
                bnd.any   = 1'b1;
                bnd.burst = 1'b1;
            end
            if (r_pix < win_w) begin
                case (r_cph)
                    2'd0: begin
                        n_chold = {11'd0, i_byte[7:3]};
                        n_cph   = 2'd1;
                    end
                    2'd1: begin
                        n_chold = r_chold | {5'd0, i_byte[7:2], 5'd0};
                        n_cph   = 2'd2;
                    end
                    default: begin
                        n_chold   = r_chold | {i_byte[7:3], 11'd0};
                        n_cph     = 2'd0;
                        n_pix     = r_pix + 11'd1;
                        bnd.any   = 1'b1;
                        bnd.pixel = 1'b1;
                        bnd.pix   = r_chold | {i_byte[7:3], 11'd0};
                    end
                endcase
            end
            if (bnd.pixel && (r_pix + 11'd1 == win_w) && (r_row == r_ys)) begin
                bnd.finish = 1'b1;
                n_phase    = PH_DONE;
            end else begin
                n_bir = r_bir + 12'd1;
                if (r_bir + 12'd1 >= r_stride) begin
                    n_bir = '0;
                    n_pix = '0;
                    n_cph = '0;
                    n_row = r_row - 10'd1;
                end
            end
        end
    end

    assign o_bundle = bnd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HEADER;
            r_pos    <= '0;
            r_pdo    <= '0;
            r_ih     <= '0;
            r_hs     <= '0;
            r_fro    <= '0;
            r_iw     <= '0;
            r_pix    <= '0;
            r_stride <= '0;
            r_bir    <= '0;
            r_xs     <= '0;
            r_xe     <= '0;
            r_ys     <= '0;
            r_row    <= '0;
            r_cph    <= '0;
            r_chold  <= '0;
        end else if (i_fire) begin
            r_phase  <= n_phase;
            r_pos    <= n_pos;
            r_pdo    <= n_pdo;
            r_ih     <= n_ih;
            r_hs     <= n_hs;
            r_fro    <= n_fro;
            r_iw     <= n_iw;
            r_pix    <= n_pix;
            r_stride <= n_stride;
            r_bir    <= n_bir;
            r_xs     <= n_xs;
            r_xe     <= n_xe;
            r_ys     <= n_ys;
            r_row    <= n_row;
            r_cph    <= n_cph;
            r_chold  <= n_chold;
        end
    end

endmodule

>>> design/bmpdisp_emit.sv
// Result register and sequencer: walks one byte's results out one per transfer.
// Depends on bmpdisp_pkg and bmpdisp_res_if.
module bmpdisp_emit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_fire,
    input  bmpdisp_pkg::t_bundle i_bundle,
    output logic                 o_in_ready,
    bmpdisp_res_if.source        m_out
);
    import bmpdisp_pkg::*;

    logic       r_busy;
    logic [3:0] r_seq;
    t_bundle    r_b;

    logic [3:0] n_seq, start_seq;
    logic       done;
    t_item      it;

    always_comb begin
        done  = 1'b1;
        n_seq = r_seq;
        if (r_seq < SEQ_BURST_END) begin
            done  = 1'b0;
            n_seq = r_seq + 4'd1;
        end else if (r_seq == SEQ_BURST_END) begin
            done  = !r_b.pixel;
            n_seq = SEQ_PIXEL;
        end else if (r_seq == SEQ_PIXEL) begin
            done  = !r_b.finish;
            n_seq = SEQ_FINISH;
        end
    end

    always_comb begin
        it = burst_item(r_seq, r_b.c0, r_b.c1, r_b.row);
        case (r_seq)
            SEQ_PIXEL: begin
                it.kind  = K_PIXEL;
                it.value = r_b.pix;
            end
            SEQ_FINISH: begin
                it.kind  = K_FINISH;
                it.value = '0;
            end
            SEQ_SINGLE: begin
                it.kind  = r_b.single_kind;
                it.value = '0;
            end
            default: it.value = it.value;
        endcase
    end

    assign start_seq = i_bundle.single ? SEQ_SINGLE :
                       i_bundle.burst  ? 4'd0 : SEQ_PIXEL;

    assign m_out.valid = r_busy;
    assign m_out.kind  = it.kind;
    assign m_out.value = it.value;
    assign m_out.last  = done;
    assign o_in_ready  = !r_busy || (done && m_out.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_seq  <= '0;
        end else if (i_fire) begin
            r_busy <= i_bundle.any;
            r_seq  <= start_seq;
        end else if (r_busy && m_out.ready) begin
            r_busy <= !done;
            r_seq  <= n_seq;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_b <= i_bundle;
        end
    end

endmodule
